>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the record stream parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/krsp_pkg.sv
// ---------------------------------------------------------------------------
// krsp_pkg
// Types and codes shared by the keyed record stream parser modules.
// ---------------------------------------------------------------------------
package krsp_pkg;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_KEY,
    PH_LEN,
    PH_DATA
  } phase_e;

  localparam logic [2:0] ROLE_TYPE     = 3'd0;
  localparam logic [2:0] ROLE_KEY      = 3'd1;
  localparam logic [2:0] ROLE_LENGTH   = 3'd2;
  localparam logic [2:0] ROLE_DATA     = 3'd3;
  localparam logic [2:0] ROLE_TERMINAL = 3'd4;
  localparam logic [2:0] ROLE_IGNORED  = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE    = 3'd1;
  localparam logic [2:0] ST_EOF_KEY     = 3'd2;
  localparam logic [2:0] ST_EOF_LENGTH  = 3'd3;
  localparam logic [2:0] ST_LENGTH_PAST = 3'd4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTED_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT    = 2'd3;

  localparam logic [7:0]  ACCEPTED_TYPE_RST = 8'd4;
  localparam logic [7:0]  REMOVE_CODE_RST   = 8'd254;
  localparam logic [7:0]  TERMINAL_CODE_RST = 8'd255;
  localparam logic [31:0] BYTE_LIMIT_RST    = 32'd0;

  typedef struct packed {
    logic [7:0]  accepted_type;
    logic [7:0]  remove_code;
    logic [7:0]  terminal_code;
    logic [31:0] byte_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       section_start;
  } in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic        record_is_delete;
    logic [4:0]  key_index;
    logic        record_end;
    logic [2:0]  status;
    logic        section_done;
    logic        ended_on_terminal;
    logic [31:0] data_length;
    logic [31:0] added_total;
    logic [31:0] deleted_total;
  } out_t;

endpackage

>>> hw/rtl/keyed_record_stream_parser.sv
// ---------------------------------------------------------------------------
// keyed_record_stream_parser
// Byte-level parser for a stream of keyed map records with role tagging.
// ---------------------------------------------------------------------------
// Takes one stream byte per clock and returns one tagged result item per
// byte, one item per cycle unless out_ready stalls the output. An input
// register feeds the parse update, which sets the rate, into the output
// register. The output register frees the input side while a result waits.
// Configuration is written through a plain write port (index 0 accepted
// type, 1 remove code, 2 terminal code, 3 byte limit) while no item is in
// flight: the user, not the block, ensures this. No clearing pass after reset.
`include "assert_macros.svh"

module keyed_record_stream_parser #(
  parameter int KEY_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  krsp_pkg::in_t                       in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output krsp_pkg::out_t                      out_item,
  input  logic                                cfg_we,
  input  logic [krsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [krsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import krsp_pkg::*;

  cfg_t  cfg;
  logic  s1_valid;
  in_t   s1_item;
  logic  out_free;
  logic  adv;
  out_t  res;

  assign out_free = !out_valid || out_ready;
  assign adv      = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accepted_type <= ACCEPTED_TYPE_RST;
      cfg.remove_code   <= REMOVE_CODE_RST;
      cfg.terminal_code <= TERMINAL_CODE_RST;
      cfg.byte_limit    <= BYTE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEPTED_TYPE: cfg.accepted_type <= cfg_data[7:0];
        CFG_REMOVE_CODE:   cfg.remove_code   <= cfg_data[7:0];
        CFG_TERMINAL_CODE: cfg.terminal_code <= cfg_data[7:0];
        CFG_BYTE_LIMIT:    cfg.byte_limit    <= cfg_data[31:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  krsp_core #(
    .KEY_BYTES(KEY_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (adv),
    .in_item(s1_item),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= res;
    end
  end

  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !out_free, s1_valid, "held item dropped from input register")
  `ASSERT_NEXT(a_adv_out, clk, rst, adv, out_valid, "advanced item missing from output register")
  `ASSERT_NEXT(a_in_lands, clk, rst, in_valid && in_ready, s1_valid, "accepted item not in input register")

endmodule

>>> hw/rtl/krsp_core.sv
// ---------------------------------------------------------------------------
// krsp_core
// Parse state and per-byte update: tags one byte, advances the record phase,
// counts records and raises sticky errors when the item is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module krsp_core #(
  parameter int KEY_BYTES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  krsp_pkg::in_t  in_item,
  input  krsp_pkg::cfg_t cfg,
  output krsp_pkg::out_t res
);
  import krsp_pkg::*;

  // counter also walks the four length bytes
  localparam int KCW = (KEY_BYTES > 8) ? $clog2(KEY_BYTES) : 3;
  localparam logic [KCW-1:0] KEY_LAST = KCW'(KEY_BYTES - 1);

  phase_e      phase, phase_next, e_phase;
  logic [KCW-1:0] kc, kc_next, e_kc;
  logic [31:0] acc, acc_next, e_acc;
  logic [31:0] remaining, remaining_next, e_rem;
  logic [32:0] consumed, consumed_next, e_cons;
  logic [31:0] added, added_next, e_added;
  logic [31:0] deleted, deleted_next, e_deleted;
  logic [2:0]  err, err_next, e_err;
  logic        done, done_next, e_done;
  logic        term, term_next, e_term;
  logic        del, del_next, e_del;

  logic [7:0]  b;
  logic [32:0] limit33;
  logic [33:0] limit34;
  logic [32:0] cons1;
  logic [31:0] acc_new;
  logic [33:0] cons_key, cons_len4, cons_data;
  logic        done0;
  logic [KCW+4:0] kext;
  logic [2:0]  role;
  logic        del_o, rend;
  logic [4:0]  kidx;
  logic [31:0] dlen;

  always_comb begin
    b = in_item.stream_byte;
    if (in_item.section_start) begin
      e_phase   = PH_TYPE;
      e_kc      = '0;
      e_acc     = '0;
      e_rem     = '0;
      e_cons    = '0;
      e_added   = '0;
      e_deleted = '0;
      e_err     = ST_OK;
      e_done    = 1'b0;
      e_term    = 1'b0;
      e_del     = 1'b0;
    end else begin
      e_phase   = phase;
      e_kc      = kc;
      e_acc     = acc;
      e_rem     = remaining;
      e_cons    = consumed;
      e_added   = added;
      e_deleted = deleted;
      e_err     = err;
      e_done    = done;
      e_term    = term;
      e_del     = del;
    end

    limit33   = {1'b0, cfg.byte_limit};
    limit34   = {2'b00, cfg.byte_limit};
    cons1     = e_cons + 33'd1;
    acc_new   = e_acc | (32'(b) << {e_kc[1:0], 3'b000});
    cons_key  = {1'b0, cons1} + 34'(KEY_BYTES);
    cons_len4 = {1'b0, cons1} + 34'd4;
    cons_data = {1'b0, cons1} + {2'b00, acc_new};
    done0     = e_done || (e_err == ST_OK && e_phase == PH_TYPE && e_cons >= limit33);
    kext      = {5'b00000, e_kc};

    phase_next     = e_phase;
    kc_next        = e_kc;
    acc_next       = e_acc;
    remaining_next = e_rem;
    consumed_next  = e_cons;
    added_next     = e_added;
    deleted_next   = e_deleted;
    err_next       = e_err;
    done_next      = done0;
    term_next      = e_term;
    del_next       = e_del;

    role  = ROLE_IGNORED;
    del_o = 1'b0;
    kidx  = '0;
    rend  = 1'b0;
    dlen  = '0;

    if (!done0 && e_err == ST_OK) begin
      consumed_next = cons1;
      unique case (e_phase)
        PH_TYPE: begin
          if (b == cfg.terminal_code) begin
            role      = ROLE_TERMINAL;
            done_next = 1'b1;
            term_next = 1'b1;
          end else begin
            role     = ROLE_TYPE;
            del_next = (b != cfg.accepted_type) && (b == cfg.remove_code);
            del_o    = del_next;
            if (cons_key > limit34) begin
              err_next = ST_EOF_KEY;
            end else if (b != cfg.accepted_type && b != cfg.remove_code) begin
              err_next = ST_BAD_TYPE;
            end else begin
              phase_next = PH_KEY;
              kc_next    = '0;
            end
          end
        end
        PH_KEY: begin
          role    = ROLE_KEY;
          del_o   = e_del;
          kidx    = kext[4:0];
          kc_next = e_kc + KCW'(1);
          if (e_kc == KEY_LAST) begin
            if (!e_del) begin
              if (cons_len4 > limit34) begin
                err_next = ST_EOF_LENGTH;
              end else begin
                phase_next = PH_LEN;
                kc_next    = '0;
                acc_next   = '0;
              end
            end else begin
              rend         = 1'b1;
              deleted_next = e_deleted + 32'd1;
              phase_next   = PH_TYPE;
              kc_next      = '0;
            end
          end
        end
        PH_LEN: begin
          role     = ROLE_LENGTH;
          acc_next = acc_new;
          kc_next  = e_kc + KCW'(1);
          if (e_kc[1:0] == 2'd3) begin
            kc_next = '0;
            dlen    = acc_new;
            if (acc_new != 32'd0 && cons_data > limit34) begin
              err_next = ST_LENGTH_PAST;
            end else if (acc_new == 32'd0) begin
              rend       = 1'b1;
              added_next = e_added + 32'd1;
              phase_next = PH_TYPE;
            end else begin
              remaining_next = acc_new;
              phase_next     = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          role           = ROLE_DATA;
          dlen           = e_acc;
          remaining_next = e_rem - 32'd1;
          if (e_rem == 32'd1) begin
            rend       = 1'b1;
            added_next = e_added + 32'd1;
            phase_next = PH_TYPE;
          end
        end
      endcase
    end

    if (!done_next && err_next == ST_OK && phase_next == PH_TYPE &&
        consumed_next >= limit33) begin
      done_next = 1'b1;
    end

    res.byte_out          = b;
    res.byte_role         = role;
    res.record_is_delete  = del_o;
    res.key_index         = kidx;
    res.record_end        = rend;
    res.status            = err_next;
    res.section_done      = done_next;
    res.ended_on_terminal = term_next;
    res.data_length       = dlen;
    res.added_total       = added_next;
    res.deleted_total     = deleted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TYPE;
      kc        <= '0;
      acc       <= '0;
      remaining <= '0;
      consumed  <= '0;
      added     <= '0;
      deleted   <= '0;
      err       <= ST_OK;
      done      <= 1'b0;
      term      <= 1'b0;
      del       <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      kc        <= kc_next;
      acc       <= acc_next;
      remaining <= remaining_next;
      consumed  <= consumed_next;
      added     <= added_next;
      deleted   <= deleted_next;
      err       <= err_next;
      done      <= done_next;
      term      <= term_next;
      del       <= del_next;
    end
  end

  `ASSERT_IMPL(a_end_role, clk, rst, take && res.record_end,
    res.byte_role == ROLE_KEY || res.byte_role == ROLE_LENGTH || res.byte_role == ROLE_DATA,
    "record end on a byte that cannot close a record")
  `ASSERT_IMPL(a_live_tagged, clk, rst, take && !res.section_done && res.status == ST_OK,
    res.byte_role != ROLE_IGNORED, "byte ignored while section is live")
  `ASSERT_IMPL(a_len_count, clk, rst, phase == PH_LEN, kc < KCW'(4),
    "length byte counter out of range")
  `ASSERT_NEXT(a_err_sticky, clk, rst, take && res.status != ST_OK && !$past(rst),
    (take && in_item.section_start) || err != ST_OK,
    "error status lost without section start")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed record stream parser: byte sections are
// queued for a valid/ready driver, a cycle-free parse model predicts every
// tagged result item, and a monitor compares each result field by field.
// ---------------------------------------------------------------------------
module testbench;
  import krsp_pkg::*;

  localparam int KEY_LEN = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keyed_record_stream_parser #(.KEY_BYTES(KEY_LEN)) u_top (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_t stream_bytes[$];
  in_t staged[$];
  out_t predicted_results[$];
  out_t want_item;

  logic in_taken = 1'b0;
  bit quiet = 0;
  bit hold_req = 0;
  bit held = 0;
  int hold_left = 0;
  int fail_count = 0;
  int bytes_queued = 0;
  int bytes_in = 0;
  int sections = 0;
  int records_closed = 0;
  int faults_raised = 0;
  int ignored_bytes = 0;

  // parse model: registers and section state
  logic [7:0] reg_accepted, reg_remove, reg_terminal;
  logic [31:0] reg_limit;
  phase_e cur_phase;
  logic [31:0] field_pos, len_acc, data_left, added_cnt, deleted_cnt;
  logic [32:0] consumed;
  logic [2:0] sec_status;
  logic sec_done, on_terminal, rec_delete;

  function automatic void clear_section();
    cur_phase = PH_TYPE;
    field_pos = '0;
    len_acc = '0;
    data_left = '0;
    consumed = '0;
    added_cnt = '0;
    deleted_cnt = '0;
    sec_status = ST_OK;
    sec_done = 1'b0;
    on_terminal = 1'b0;
    rec_delete = 1'b0;
  endfunction

  function automatic void close_at_boundary(logic [63:0] lim);
    if (!sec_done && sec_status == ST_OK && cur_phase == PH_TYPE && 64'(consumed) >= lim)
      sec_done = 1'b1;
  endfunction

  function automatic out_t parse_byte(in_t it);
    out_t r;
    logic [7:0] b;
    logic [63:0] lim;
    b = it.stream_byte;
    r = '0;
    r.byte_out = b;
    r.byte_role = ROLE_IGNORED;
    if (it.section_start) clear_section();
    lim = 64'(reg_limit);
    close_at_boundary(lim);
    if (!sec_done && sec_status == ST_OK) begin
      consumed = consumed + 33'd1;
      case (cur_phase)
        PH_TYPE: begin
          if (b == reg_terminal) begin
            r.byte_role = ROLE_TERMINAL;
            sec_done = 1'b1;
            on_terminal = 1'b1;
          end else begin
            r.byte_role = ROLE_TYPE;
            rec_delete = (b != reg_accepted) && (b == reg_remove);
            r.record_is_delete = rec_delete;
            if (64'(consumed) + 64'(KEY_LEN) > lim) begin
              sec_status = ST_EOF_KEY;
            end else if (b != reg_accepted && b != reg_remove) begin
              sec_status = ST_BAD_TYPE;
            end else begin
              cur_phase = PH_KEY;
              field_pos = '0;
            end
          end
        end
        PH_KEY: begin
          r.byte_role = ROLE_KEY;
          r.record_is_delete = rec_delete;
          r.key_index = field_pos[4:0];
          field_pos = field_pos + 1;
          if (field_pos >= 32'(KEY_LEN)) begin
            if (!rec_delete) begin
              if (64'(consumed) + 64'd4 > lim) begin
                sec_status = ST_EOF_LENGTH;
              end else begin
                cur_phase = PH_LEN;
                field_pos = '0;
                len_acc = '0;
              end
            end else begin
              r.record_end = 1'b1;
              deleted_cnt = deleted_cnt + 1;
              cur_phase = PH_TYPE;
              field_pos = '0;
            end
          end
        end
        PH_LEN: begin
          r.byte_role = ROLE_LENGTH;
          len_acc = len_acc | (32'(b) << (8 * field_pos[1:0]));
          field_pos = field_pos + 1;
          if (field_pos >= 32'd4) begin
            field_pos = '0;
            r.data_length = len_acc;
            if (len_acc != 0 && 64'(consumed) + 64'(len_acc) > lim) begin
              sec_status = ST_LENGTH_PAST;
            end else if (len_acc == 0) begin
              r.record_end = 1'b1;
              added_cnt = added_cnt + 1;
              cur_phase = PH_TYPE;
            end else begin
              data_left = len_acc;
              cur_phase = PH_DATA;
            end
          end
        end
        default: begin
          r.byte_role = ROLE_DATA;
          r.data_length = len_acc;
          data_left = data_left - 1;
          if (data_left == 0) begin
            r.record_end = 1'b1;
            added_cnt = added_cnt + 1;
            cur_phase = PH_TYPE;
          end
        end
      endcase
      close_at_boundary(lim);
    end
    r.status = sec_status;
    r.section_done = sec_done;
    r.ended_on_terminal = on_terminal;
    r.added_total = added_cnt;
    r.deleted_total = deleted_cnt;
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (stream_bytes.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
        in_valid <= 1'b1;
        in_item <= stream_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      predicted_results.push_back(parse_byte(in_item));
      bytes_in++;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !held) begin
      held <= 1'b1;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("result item with nothing outstanding");
        fail_count++;
      end else begin
        want_item = predicted_results.pop_front();
        check_field("byte_out", want_item.byte_out, out_item.byte_out);
        check_field("byte_role", want_item.byte_role, out_item.byte_role);
        check_field("record_is_delete", want_item.record_is_delete, out_item.record_is_delete);
        check_field("key_index", want_item.key_index, out_item.key_index);
        check_field("record_end", want_item.record_end, out_item.record_end);
        check_field("status", want_item.status, out_item.status);
        check_field("section_done", want_item.section_done, out_item.section_done);
        check_field("ended_on_terminal", want_item.ended_on_terminal,
                    out_item.ended_on_terminal);
        check_field("data_length", want_item.data_length, out_item.data_length);
        check_field("added_total", want_item.added_total, out_item.added_total);
        check_field("deleted_total", want_item.deleted_total, out_item.deleted_total);
        if (want_item.record_end) records_closed++;
        if (want_item.byte_role == ROLE_IGNORED) ignored_bytes++;
        else if (want_item.status != ST_OK) faults_raised++;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (stream_bytes.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ACCEPTED_TYPE: reg_accepted = val[7:0];
      CFG_REMOVE_CODE:   reg_remove = val[7:0];
      CFG_TERMINAL_CODE: reg_terminal = val[7:0];
      default:           reg_limit = val;
    endcase
  endtask

  task automatic stage(input logic [7:0] b, input bit restart = 0);
    in_t it;
    it.stream_byte = b;
    it.section_start = restart || (staged.size() == 0);
    staged.push_back(it);
  endtask

  task automatic stage_key(input logic [7:0] typ, input bit restart = 0);
    stage(typ, restart);
    repeat (KEY_LEN) stage(8'($urandom));
  endtask

  task automatic stage_len(input logic [31:0] len);
    for (int i = 0; i < 4; i++) stage(len[8*i +: 8]);
  endtask

  task automatic stage_data(input int n);
    repeat (n) stage(8'($urandom));
  endtask

  task automatic launch(input logic [31:0] lim);
    set_reg(CFG_BYTE_LIMIT, lim);
    foreach (staged[i]) stream_bytes.push_back(staged[i]);
    bytes_queued += staged.size();
    staged.delete();
    sections++;
  endtask

  initial begin : stimulus
    int nrec, kind, body, m, start, rnd_sections;
    logic [31:0] len, lim;
    reg_accepted = ACCEPTED_TYPE_RST;
    reg_remove = REMOVE_CODE_RST;
    reg_terminal = TERMINAL_CODE_RST;
    reg_limit = BYTE_LIMIT_RST;
    clear_section();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // zero limit, nothing consumed: first byte already ignored
    stage(8'h04); stage(8'h00); launch(32'd0);
    // terminal, then ignored
    stage(8'hFF); stage(8'h00); launch(32'd1000);
    // bad type
    stage(8'h00); stage(8'h04); launch(32'd1000);
    // key would pass the limit
    stage(8'h04); launch(32'd10);
    // length would pass the limit
    stage_key(8'h04); launch(32'd35);
    // data would pass the limit
    stage_key(8'h04); stage_len(32'd5); stage_data(2); launch(32'd39);
    // zero length fills the limit exactly
    stage_key(8'h04); stage_len(32'd0); stage(8'hFF); launch(32'd37);
    // remove record, then a short accepted record and terminal
    stage_key(8'hFE); stage_key(8'h04); stage_len(32'd1); stage_data(1); stage(8'hFF);
    launch(32'd2000);
    // type equal to both codes counts as accepted
    set_reg(CFG_REMOVE_CODE, 32'd4);
    stage_key(8'h04); stage_len(32'd0); stage(8'hFF); launch(32'd1000);
    // extreme codes, length and limit
    set_reg(CFG_ACCEPTED_TYPE, 32'd255);
    set_reg(CFG_REMOVE_CODE, 32'd0);
    set_reg(CFG_TERMINAL_CODE, 32'h80);
    stage_key(8'h00); stage_key(8'hFF); stage_len(32'hFFFF_FFFF); stage(8'h00);
    launch(32'hFFFF_FFFF);
    // terminal wins over accepted
    set_reg(CFG_ACCEPTED_TYPE, 32'd0);
    set_reg(CFG_REMOVE_CODE, 32'd255);
    set_reg(CFG_TERMINAL_CODE, 32'd0);
    stage(8'h00); stage(8'h00); launch(32'd100);
    set_reg(CFG_ACCEPTED_TYPE, 32'(ACCEPTED_TYPE_RST));
    set_reg(CFG_REMOVE_CODE, 32'(REMOVE_CODE_RST));
    set_reg(CFG_TERMINAL_CODE, 32'(TERMINAL_CODE_RST));

    start = bytes_queued;
    rnd_sections = 0;
    while (bytes_queued - start < 1200) begin
      if ($urandom_range(3) == 0) begin
        set_reg(CFG_ACCEPTED_TYPE, $urandom_range(255));
        set_reg(CFG_REMOVE_CODE, ($urandom_range(7) == 0) ? 32'(reg_accepted)
                                                            : 32'($urandom_range(255)));
        set_reg(CFG_TERMINAL_CODE, $urandom_range(255));
      end
      if (rnd_sections == 4) begin
        hold_req = 1;
        stage_key(reg_accepted); stage_len(32'd150); stage_data(150);
      end
      quiet = (rnd_sections >= 8 && rnd_sections < 11);
      nrec = $urandom_range(4, 1);
      for (int r = 0; r < nrec; r++) begin
        kind = $urandom_range(19);
        if (kind < 12) begin
          len = (kind == 0) ? $urandom_range(60, 9) : $urandom_range(8);
          stage_key(reg_accepted); stage_len(len); stage_data(len);
        end else if (kind < 17) begin
          stage_key(reg_remove);
        end else if (kind == 17) begin
          stage_key(8'($urandom));
        end else if (kind == 18) begin
          // restart in the middle of a section
          stage_key(reg_accepted, 1); stage_len(32'd0);
        end else begin
          stage(reg_accepted); stage_data($urandom_range(40));
          break;
        end
      end
      if ($urandom_range(1) == 1) stage(reg_terminal);
      body = staged.size();
      if ($urandom_range(3) == 0) stage_data($urandom_range(6, 1));
      m = $urandom_range(9);
      if (m < 5) lim = body + $urandom_range(8);
      else if (m < 7) lim = body - 1;
      else if (m < 9) lim = $urandom_range(body);
      else lim = $urandom;
      launch(lim);
      rnd_sections++;
    end
    quiet = 0;

    wait_idle();
    repeat (6) @(posedge clk);
    $display("run covered %0d bytes in %0d sections: %0d records closed, %0d faults raised",
             bytes_in, sections, records_closed, faults_raised);
    $display("%0d bytes came back tagged as ignored after a done or fault", ignored_bytes);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", predicted_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
